// File: rtl/core/f3216_pkg.sv
package f3216_pkg;

  typedef enum logic [2:0] {
    OP_F32_F16 = 3'd0,
    OP_F16_F32 = 3'd1,
    OP_F16_I8  = 3'd2,
    OP_F16_I16 = 3'd3,
    OP_F16_I32 = 3'd4,
    OP_F16_I64 = 3'd5
  } op_e;

  localparam logic [15:0] HalfQnan = 16'h7E00;
  localparam logic [15:0] HalfInf  = 16'h7C00;
  localparam logic [31:0] SingleQnan = 32'h7FC00000;
  localparam logic [31:0] SingleInf  = 32'h7F800000;

  // Decoded half operand shared by the widening and integer paths.
  typedef struct packed {
    logic        sign;
    logic [4:0]  expo;
    logic [9:0]  man;
  } half_t;

endpackage

// File: rtl/core/f3216_stage.sv
module f3216_stage #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;
  logic             load;

  // A stage takes a new item when it is empty or its item leaves this cycle.
  assign stall_o = valid_q & stall_i;
  assign load    = ~stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && stall_i) |=> (valid_q && $stable(data_q)))
    else $error("stage dropped a stalled item");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> valid_q)
    else $error("stage lost an accepted item");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_q && !valid_i) |=> !valid_q)
    else $error("stage invented an item");
`endif

endmodule

// File: rtl/core/fp32_fp16_convert.sv
// Channel | valid    | stall    | payload
// in      | valid_i  | stall_o  | operation_i, value_in_i
// out     | valid_o  | stall_i  | float_bits_o, int_value_o
// One item is accepted per cycle while stall_o is low.
// Three register stages: decode/align, round/shift, saturate/pack.
// rst_ni clears only the stage valid bits; payload registers are not reset.
// A stall holds only the full stages; stall_o rises only when stage 1 is full.
module fp32_fp16_convert (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [2:0]                  operation_i,
  input  logic [31:0]                 value_in_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [31:0]                 float_bits_o,
  output logic signed [63:0]          int_value_o
);
  import f3216_pkg::*;

  // ---------------- stage 1: decode ----------------
  typedef struct packed {
    logic [2:0]  op;
    logic        sign;
    // narrowing
    logic [1:0]  nkind;    // 0 normal, 1 subnormal, 2 fixed result
    logic [15:0] nfix;
    logic [4:0]  nexp;
    logic [23:0] nfull;
    logic [3:0]  nshift;   // 0 for normal, 1..11 subnormal
    // widening / integer
    half_t       h;
  } s1_t;

  s1_t s1_d, s1_q;
  logic v1, st1;

  always_comb begin
    logic [7:0] e;
    logic [22:0] m;
    logic [8:0] he;
    e = value_in_i[30:23];
    m = value_in_i[22:0];
    he = {1'b0, e} - 9'd112;
    s1_d = '0;
    s1_d.op = operation_i;
    s1_d.sign = value_in_i[31];
    s1_d.h = value_in_i[15:0];
    s1_d.nfull = {1'b1, m};
    s1_d.nexp = he[4:0];
    if (e == 8'hFF) begin
      s1_d.nkind = 2'd2;
      s1_d.nfix = (m != 0) ? HalfQnan : HalfInf;
    end else if (e >= 8'd143) begin
      s1_d.nkind = 2'd2;
      s1_d.nfix = HalfInf;
    end else if (e >= 8'd113) begin
      s1_d.nkind = 2'd0;
    end else if (e >= 8'd102) begin
      s1_d.nkind = 2'd1;
      s1_d.nshift = 4'(8'd113 - e);
    end else begin
      s1_d.nkind = 2'd2;
      s1_d.nfix = 16'h0000;
    end
  end

  f3216_stage #(.Width($bits(s1_t))) u_s1 (
    .clk_i, .rst_ni, .valid_i(valid_i), .stall_o(stall_o), .data_i(s1_d),
    .valid_o(v1), .stall_i(st1), .data_o(s1_q)
  );

  // ---------------- stage 2: round / align ----------------
  typedef struct packed {
    logic [2:0]  op;
    logic        sign;
    logic [14:0] nres;      // narrowed magnitude
    logic [30:0] wres;      // widened magnitude
    logic        inan;
    logic        iinf;
    logic [40:0] mag;       // integer magnitude, saturates later
  } s2_t;

  s2_t s2_d, s2_q;
  logic v2, st2;

  always_comb begin
    logic [23:0] kept;
    logic        sticky;
    logic [12:0] guard;
    logic [10:0] q;
    logic        up;
    logic [15:0] rn;
    logic [3:0]  lz;
    logic [9:0]  wm;
    logic [10:0] sig;
    logic [4:0]  e;
    kept = s1_q.nfull >> s1_q.nshift;
    sticky = (s1_q.nfull & ((24'd1 << s1_q.nshift) - 24'd1)) != 24'd0;
    guard = kept[12:0];
    q = kept[23:13];
    up = 1'b0;
    rn = '0;
    s2_d = '0;
    s2_d.op = s1_q.op;
    // Narrowing takes the single's sign; every other operation takes the half's.
    s2_d.sign = (s1_q.op == OP_F32_F16) ? s1_q.sign : s1_q.h.sign;
    case (s1_q.nkind)
      2'd0: begin
        up = (guard > 13'h1000) || (guard == 13'h1000 && (sticky || q[0]));
        // Carry out of the mantissa bumps the exponent, possibly to infinity.
        rn = {1'b0, s1_q.nexp, q[9:0]} + {15'd0, up};
        s2_d.nres = rn[14:0];
      end
      2'd1: begin
        up = (guard > 13'h1000) || (guard == 13'h1000 && (sticky || q[0]));
        rn = {5'd0, q} + {15'd0, up};
        s2_d.nres = rn[14:0];
      end
      default: s2_d.nres = s1_q.nfix[14:0];
    endcase
    // widening
    lz = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (s1_q.h.man[i] && lz == 4'd0) lz = 4'(10 - i);
    end
    wm = 10'(s1_q.h.man << lz);
    if (s1_q.h.expo == 5'h1F) begin
      s2_d.wres = (s1_q.h.man != 0) ? SingleQnan[30:0] : SingleInf[30:0];
    end else if (s1_q.h.expo == 5'd0) begin
      if (s1_q.h.man == 0) s2_d.wres = '0;
      else s2_d.wres = {8'(8'd113 - {4'd0, lz}), wm, 13'd0};
    end else begin
      s2_d.wres = {8'({3'd0, s1_q.h.expo} + 8'd112), s1_q.h.man, 13'd0};
    end
    // integer: exponents up to 30 give magnitudes below 2^16, so 41 bits cover all
    e = s1_q.h.expo;
    sig = {1'b1, s1_q.h.man};
    s2_d.inan = (e == 5'h1F) && (s1_q.h.man != 0);
    s2_d.iinf = (e == 5'h1F) && (s1_q.h.man == 0);
    if (e == 5'd0 || e == 5'h1F) s2_d.mag = '0;
    else if (e >= 5'd25) s2_d.mag = 41'({30'd0, sig} << (e - 5'd25));
    else s2_d.mag = 41'({30'd0, sig} >> (5'd25 - e));
  end

  f3216_stage #(.Width($bits(s2_t))) u_s2 (
    .clk_i, .rst_ni, .valid_i(v1), .stall_o(st1), .data_i(s2_d),
    .valid_o(v2), .stall_i(st2), .data_o(s2_q)
  );

  // ---------------- stage 3: saturate / pack ----------------
  typedef struct packed {
    logic [31:0] fb;
    logic [63:0] iv;
  } s3_t;

  s3_t s3_d, s3_q;

  always_comb begin
    logic [63:0] maxpos;
    logic [63:0] maxneg;
    logic [63:0] m;
    maxpos = 64'h7F;
    case (s2_q.op)
      OP_F16_I16: maxpos = 64'h7FFF;
      OP_F16_I32: maxpos = 64'h7FFF_FFFF;
      OP_F16_I64: maxpos = 64'h7FFF_FFFF_FFFF_FFFF;
      default:    maxpos = 64'h7F;
    endcase
    maxneg = maxpos + 64'd1;
    m = {23'd0, s2_q.mag};
    s3_d = '0;
    case (s2_q.op)
      OP_F32_F16: s3_d.fb = {16'd0, s2_q.sign, s2_q.nres};
      OP_F16_F32: s3_d.fb = {s2_q.sign, s2_q.wres};
      OP_F16_I8, OP_F16_I16, OP_F16_I32, OP_F16_I64: begin
        if (s2_q.inan) s3_d.iv = '0;
        else if (s2_q.iinf) s3_d.iv = s2_q.sign ? (64'd0 - maxneg) : maxpos;
        else if (s2_q.sign) s3_d.iv = 64'd0 - ((m > maxneg) ? maxneg : m);
        else s3_d.iv = (m > maxpos) ? maxpos : m;
      end
      default: s3_d = '0;
    endcase
  end

  f3216_stage #(.Width($bits(s3_t))) u_s3 (
    .clk_i, .rst_ni, .valid_i(v2), .stall_o(st2), .data_i(s3_d),
    .valid_o(valid_o), .stall_i(stall_i), .data_o(s3_q)
  );

  assign float_bits_o = s3_q.fb;
  assign int_value_o  = $signed(s3_q.iv);

`ifndef SYNTHESIS
  a_zero_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && s2_q.op == OP_F32_F16) |-> (s3_d.iv == 64'd0))
    else $error("narrowing produced an integer");
  a_half_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && s2_q.op == OP_F32_F16) |-> (s3_d.fb[31:16] == 16'd0))
    else $error("half result has upper bits set");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_o) |-> !stall_o)
    else $error("pipeline stalled while output empty");
`endif

endmodule
